FILE: design/piaw_pkg.sv
package piaw_pkg;

  // Output limit of the clamp, in integer units
  localparam int unsigned OutputMax = 4095;
  localparam int unsigned ControlW  = 12;
  // Clamp limit in Q16.16
  localparam logic [31:0] UsatMax   = 32'(OutputMax * 65536);
  // Code that the control field shows at the upper limit
  localparam logic [ControlW-1:0] ControlAtMax = ControlW'(OutputMax);
  // Back-calculation gain 0.1 in Q0.16
  localparam logic [13:0] AwGain    = 14'd6554;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP         = 3'd0,
    REG_KI         = 3'd1,
    REG_BETA       = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_TARGET     = 3'd4,
    REG_USE_TARGET = 3'd5
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_WT,
    ST_MUL_P,
    ST_MUL_E,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_MUL_AWHI,
    ST_MUL_AWLO,
    ST_AW_SUM,
    ST_COMMIT
  } st_e;

  // Operand pair of the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE,
    MS_WT,
    MS_P,
    MS_E,
    MS_HI,
    MS_LO,
    MS_AWHI,
    MS_AWLO
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     clear;
    mul_sel_e mul_sel;
    logic     aw_sum;
    logic     commit;
  } cmd_t;

endpackage

FILE: design/piaw_in_if.sv
interface piaw_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] setpoint;
  logic signed [31:0] measurement;

  modport source (output valid, action, setpoint, measurement, input ready);
  modport sink   (input valid, action, setpoint, measurement, output ready);
endinterface

FILE: design/piaw_out_if.sv
interface piaw_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        control;
  logic               saturated;
  logic signed [47:0] proportional_term;
  logic signed [47:0] integral_term;

  modport source (output valid, control, saturated, proportional_term, integral_term,
                  input ready);
  modport sink   (input valid, control, saturated, proportional_term, integral_term,
                  output ready);
endinterface

FILE: design/piaw_ctrl.sv
module piaw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_action_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output piaw_pkg::cmd_t cmd_o
);
  import piaw_pkg::*;

  st_e  state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_action_i) state_d = ST_MUL_WT;
      end
      ST_MUL_WT:   state_d = ST_MUL_P;
      ST_MUL_P:    state_d = ST_MUL_E;
      ST_MUL_E:    state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_MUL_LO;
      ST_MUL_LO:   state_d = ST_MUL_AWHI;
      ST_MUL_AWHI: state_d = ST_MUL_AWLO;
      ST_MUL_AWLO: state_d = ST_AW_SUM;
      ST_AW_SUM:   state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i && !in_action_i;
        cmd_o.clear   = in_valid_i && in_action_i;
      end
      ST_MUL_WT:   cmd_o.mul_sel = MS_WT;
      ST_MUL_P:    cmd_o.mul_sel = MS_P;
      ST_MUL_E:    cmd_o.mul_sel = MS_E;
      ST_MUL_HI:   cmd_o.mul_sel = MS_HI;
      ST_MUL_LO:   cmd_o.mul_sel = MS_LO;
      ST_MUL_AWHI: cmd_o.mul_sel = MS_AWHI;
      ST_MUL_AWLO: cmd_o.mul_sel = MS_AWLO;
      ST_AW_SUM:   cmd_o.aw_sum  = 1'b1;
      ST_COMMIT:   cmd_o.commit  = out_free;
      default:     cmd_o         = '0;
    endcase
  end

  // Result valid: set on commit, drop once taken
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/piaw_dp.sv
module piaw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [piaw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [piaw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic signed [31:0]            in_setpoint_i,
  input  logic signed [31:0]            in_measurement_i,
  input  piaw_pkg::cmd_t                cmd_i,
  output logic [piaw_pkg::ControlW-1:0] control_o,
  output logic                          saturated_o,
  output logic signed [47:0]            proportional_term_o,
  output logic signed [47:0]            integral_term_o
);
  import piaw_pkg::*;

  localparam logic signed [49:0] S48Max = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] S48Min = -S48Max - 50'sd1;

  // Configuration registers
  logic [23:0]        kp_q, ki_q, period_q;
  logic [16:0]        beta_q;
  logic signed [31:0] itgt_q;
  logic               use_itgt_q;

  // Working registers
  logic signed [31:0] tgt_q, meas_q;
  logic signed [58:0] prod_q;
  logic signed [47:0] p_q;
  logic signed [48:0] u_q;
  logic [23:0]        lo_q;
  logic signed [47:0] inc_q;
  logic [31:0]        usat_q;
  logic               sat_q;
  logic signed [49:0] d_q;
  logic signed [62:0] aw_q;
  logic signed [46:0] awsh_q;
  logic signed [47:0] integral_q;

  // Result registers
  logic [ControlW-1:0] control_q;
  logic                saturated_q;
  logic signed [47:0]  prop_out_q, integ_out_q;

  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_p;
  logic signed [32:0] wt;
  logic signed [48:0] umax_s;
  logic [31:0]        usat_d;
  logic               sat_d;
  logic signed [49:0] d_d;
  logic signed [62:0] aw_tot;
  logic signed [49:0] isum;
  logic signed [47:0] i_new;

  // Weighted target, floored to Q16.16
  assign wt = signed'(prod_q[48:16]);

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MS_WT: begin
        mul_a = 34'(tgt_q);
        mul_b = 25'(beta_q);
      end
      MS_P: begin
        mul_a = 34'(wt) - 34'(meas_q);
        mul_b = 25'(kp_q);
      end
      MS_E: begin
        mul_a = 34'(tgt_q) - 34'(meas_q);
        mul_b = 25'(ki_q);
      end
      MS_HI: begin
        mul_a = 34'(signed'(prod_q[58:40]));
        mul_b = 25'(period_q);
      end
      MS_LO: begin
        mul_a = 34'(lo_q);
        mul_b = 25'(period_q);
      end
      MS_AWHI: begin
        mul_a = 34'(signed'(d_q[49:24]));
        mul_b = 25'(AwGain);
      end
      MS_AWLO: begin
        mul_a = 34'(d_q[23:0]);
        mul_b = 25'(AwGain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 59'(mul_a) * 59'(mul_b);

  // Clamp the unsaturated action to 0..OutputMax
  assign umax_s = signed'(49'(UsatMax));

  always_comb begin
    if (u_q > umax_s) begin
      usat_d = UsatMax;
      sat_d  = 1'b1;
    end else if (u_q < 49'sd0) begin
      usat_d = '0;
      sat_d  = 1'b1;
    end else begin
      usat_d = u_q[31:0];
      sat_d  = 1'b0;
    end
  end

  assign d_d = 50'(signed'({1'b0, usat_d})) - 50'(u_q);

  // Back-calculation product, both halves joined
  assign aw_tot = aw_q + signed'(63'(prod_q[37:0]));

  // Integral update with saturation to 48 bits
  assign isum = 50'(integral_q) + 50'(inc_q) + 50'(awsh_q);

  always_comb begin
    if (isum > S48Max) begin
      i_new = S48Max[47:0];
    end else if (isum < S48Min) begin
      i_new = S48Min[47:0];
    end else begin
      i_new = isum[47:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= 24'd65536;
      ki_q       <= '0;
      beta_q     <= 17'd65536;
      period_q   <= 24'd167772;
      itgt_q     <= '0;
      use_itgt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KP:         kp_q       <= cfg_wdata_i[23:0];
        REG_KI:         ki_q       <= cfg_wdata_i[23:0];
        REG_BETA:       beta_q     <= cfg_wdata_i[16:0];
        REG_PERIOD:     period_q   <= cfg_wdata_i[23:0];
        REG_TARGET:     itgt_q     <= signed'(cfg_wdata_i[31:0]);
        REG_USE_TARGET: use_itgt_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Integral state: zero on clear, update on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
    end else if (cmd_i.clear) begin
      integral_q <= '0;
    end else if (cmd_i.commit) begin
      integral_q <= i_new;
    end
  end

  // Sample operands, products and intermediate terms
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q  <= use_itgt_q ? itgt_q : in_setpoint_i;
      meas_q <= in_measurement_i;
    end
    if (cmd_i.mul_sel != MS_NONE) begin
      prod_q <= mul_p;
    end
    case (cmd_i.mul_sel)
      MS_E: begin
        p_q <= 48'(signed'(prod_q[58:16]));
      end
      MS_HI: begin
        u_q  <= 49'(p_q) + 49'(integral_q);
        lo_q <= prod_q[39:16];
      end
      MS_LO: begin
        inc_q  <= prod_q[47:0];
        usat_q <= usat_d;
        sat_q  <= sat_d;
        d_q    <= d_d;
      end
      MS_AWHI: begin
        inc_q <= inc_q + signed'({24'b0, prod_q[47:24]});
      end
      MS_AWLO: begin
        aw_q <= signed'({prod_q[38:0], 24'b0});
      end
      default: ;
    endcase
    if (cmd_i.aw_sum) begin
      awsh_q <= aw_tot[62:16];
    end
    if (cmd_i.commit) begin
      control_q   <= usat_q[16 +: ControlW];
      saturated_q <= sat_q;
      prop_out_q  <= p_q;
      integ_out_q <= i_new;
    end
  end

  assign control_o           = control_q;
  assign saturated_o         = saturated_q;
  assign proportional_term_o = prop_out_q;
  assign integral_term_o     = integ_out_q;

endmodule

FILE: design/pi_controller_antiwindup.sv
// PI controller with setpoint weighting and back-calculation anti-windup.
// Input channel (in_if): one transaction per sample. action 0 computes a
// control sample from setpoint and measurement (signed Q16.16); action 1
// clears the integral term and yields no result.
// Output channel (out_if): one transaction per compute sample carrying the
// clamped control value, the saturation flag and the P and I terms.
// Configuration: write cfg_we_i with a register index and data while idle.
// Sequence: after a compute sample is accepted, the single shared 34x25
// multiplier runs the steps WT, P, E, HI, LO, AWHI and AWLO, then AW_SUM
// forms the anti-windup term and COMMIT loads the result register; a new
// sample is accepted only once the sequencer is back in idle.
// A clear is handled in idle and the next sample may follow straight away.
// The result register decouples the sides: the next sample is accepted while
// a result waits; if the receiver still stalls when the following result is
// ready, the sequencer holds in its last step until the register frees.
// Reset clears the integral, the handshakes and loads the register defaults.
module pi_controller_antiwindup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [piaw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [piaw_pkg::CfgDataW-1:0] cfg_wdata_i,
  piaw_in_if.sink                       in_if,
  piaw_out_if.source                    out_if
);
  import piaw_pkg::*;

  cmd_t cmd;

  // Sequencer
  piaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_action_i (in_if.action),
    .out_ready_i (out_if.ready),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  piaw_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_setpoint_i       (in_if.setpoint),
    .in_measurement_i    (in_if.measurement),
    .cmd_i               (cmd),
    .control_o           (out_if.control),
    .saturated_o         (out_if.saturated),
    .proportional_term_o (out_if.proportional_term),
    .integral_term_o     (out_if.integral_term)
  );

endmodule

FILE: design/piaw_checker.sv
module piaw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_action_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [piaw_pkg::ControlW-1:0] control_i,
  input logic                          saturated_i,
  input logic signed [47:0]            proportional_term_i,
  input logic signed [47:0]            integral_term_i
);
  import piaw_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(control_i) && $stable(saturated_i)
      && $stable(proportional_term_i) && $stable(integral_term_i))
    else $error("stalled result changed");

  // A compute transaction occupies the sequencer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_action_i |=> !in_ready_i)
    else $error("input taken while a sample is in progress");

  // A clear leaves the sequencer idle
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i |=> in_ready_i)
    else $error("clear did not return to idle");

  // A saturated result sits at one of the limits
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> control_i == '0 || control_i == ControlAtMax)
    else $error("saturated result not at a limit");

endmodule

bind pi_controller_antiwindup piaw_checker u_piaw_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_if.valid),
  .in_ready_i          (in_if.ready),
  .in_action_i         (in_if.action),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .control_i           (out_if.control),
  .saturated_i         (out_if.saturated),
  .proportional_term_i (out_if.proportional_term),
  .integral_term_i     (out_if.integral_term)
);
